/* hw/rtl/pfim_pkg.sv */
// Shared widths, register indexes, status codes and configuration type.
`timescale 1ns / 1ps

package pfim_pkg;

    localparam int unsigned IDX_W      = 30;
    localparam int unsigned SIZE_W     = 11;
    localparam int unsigned PICK_W     = 2;
    localparam int unsigned REV_W      = 3;
    localparam int unsigned ST_W       = 2;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = SIZE_W;

    // Register indexes of the configuration channel.
    localparam logic [CFG_IDX_W-1:0] REG_BASE_SIZE_0  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_SIZE_1  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_SIZE_2  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_AXIS_PICK_0  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_AXIS_PICK_1  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_AXIS_PICK_2  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_REVERSE_MASK = 3'd6;

    // A pick of this value names no base axis.
    localparam logic [PICK_W-1:0] AXIS_INVALID = 2'd3;

    typedef enum logic [ST_W-1:0] {
        ST_OK       = 2'd0,
        ST_ZERO_DIM = 2'd1,
        ST_BAD_PERM = 2'd2,
        ST_RANGE    = 2'd3
    } t_status;

    typedef struct packed {
        logic [2:0][SIZE_W-1:0] size;
        logic [2:0][PICK_W-1:0] pick;
        logic [REV_W-1:0]       rev;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        size: {11'd1, 11'd1, 11'd1},
        pick: {2'd2, 2'd1, 2'd0},
        rev:  3'd0
    };

endpackage

/* hw/rtl/pfim_if.sv */
// Request, result and configuration channel interfaces.
`timescale 1ns / 1ps

interface pfim_in_if import pfim_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] out_index;

    modport source (output valid, output out_index, input ready);
    modport sink   (input valid, input out_index, output ready);
endinterface

interface pfim_out_if import pfim_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] src_index;
    t_status          status;

    modport source (output valid, output src_index, output status, input ready);
    modport sink   (input valid, input src_index, input status, output ready);
endinterface

interface pfim_cfg_if import pfim_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* hw/rtl/permuted_flipped_3d_index_map.sv */
// Top level of the permuted and flipped 3D index map.
`timescale 1ns / 1ps

// Maps a linear index into a permuted, per-axis reversed view of a 3D
// row-major array back to the linear index of the same element in the
// base array.
//
// Channels: i_in carries requests (out_index), o_out carries results
// (src_index, status), i_cfg writes the seven registers by index. Write
// configuration only while no request is in flight; i_cfg is always ready.
//
// Throughput: one request per cycle, sustained while the receiver is ready.
// The two divider pipelines compute one quotient bit per stage; their
// widths follow EW = clog2(min(MAX_EXTENT, 2047) + 1).
//
// Reset clears every pipeline valid bit and loads the register defaults.
// When the receiver stalls, ready walks back stage by stage: empty stages
// keep filling, so requests are still taken until the pipe is full.
module permuted_flipped_3d_index_map import pfim_pkg::*; #(
    parameter int unsigned MAX_EXTENT = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pfim_in_if.sink     i_in,
    pfim_out_if.source  o_out,
    pfim_cfg_if.sink    i_cfg
);

    // Extents never exceed the register range, so clamp there too.
    localparam int unsigned EXT_CAP = (MAX_EXTENT < 2047) ? MAX_EXTENT : 2047;
    localparam int unsigned EW      = $clog2(EXT_CAP + 1);
    // A valid index leaves at most 2*EW quotient bits over the fastest axis.
    localparam int unsigned Q1W     = (2 * EW < IDX_W) ? 2 * EW : IDX_W;

    t_cfg             w_cfg;
    logic [EW-1:0]    w_shape [3];
    logic [EW-1:0]    w_dim   [3];

    logic             w_chk_valid, w_chk_ready;
    logic [IDX_W-1:0] w_chk_index;
    t_status          w_chk_status;

    logic             w_lo_valid, w_lo_ready;
    logic [Q1W-1:0]   w_lo_quo;
    logic [EW-1:0]    w_lo_rem;
    logic [ST_W-1:0]  w_lo_tag;

    logic             w_hi_valid, w_hi_ready;
    logic [EW-1:0]    w_hi_quo;
    logic [EW-1:0]    w_hi_rem;
    logic [ST_W+EW-1:0] w_hi_tag;

    logic [EW-1:0]    w_crd [3];

    pfim_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (w_cfg)
    );

    // Saturate the extents, then look up the extent of each output axis.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (32'(w_cfg.size[k]) > MAX_EXTENT) w_shape[k] = EW'(EXT_CAP);
            else                                 w_shape[k] = EW'(w_cfg.size[k]);
        end
        for (int k = 0; k < 3; k++) begin
            if (w_cfg.pick[k] == AXIS_INVALID) w_dim[k] = '0;
            else                               w_dim[k] = w_shape[w_cfg.pick[k]];
        end
    end

    // Checks and element count; errors ride along with the request.
    pfim_check #(.EW(EW)) u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (w_cfg),
        .i_dim        (w_dim),
        .i_in_valid   (i_in.valid),
        .o_in_ready   (i_in.ready),
        .i_in_index   (i_in.out_index),
        .o_out_valid  (w_chk_valid),
        .i_out_ready  (w_chk_ready),
        .o_out_index  (w_chk_index),
        .o_out_status (w_chk_status)
    );

    // Split off the fastest coordinate.
    pfim_div #(.NW(IDX_W), .DW(EW), .QW(Q1W), .TW(ST_W)) u_div_lo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (w_chk_valid),
        .o_in_ready  (w_chk_ready),
        .i_in_num    (w_chk_index),
        .i_in_tag    (w_chk_status),
        .i_divisor   (w_dim[2]),
        .o_out_valid (w_lo_valid),
        .i_out_ready (w_lo_ready),
        .o_out_quo   (w_lo_quo),
        .o_out_rem   (w_lo_rem),
        .o_out_tag   (w_lo_tag)
    );

    // Split the rest into the slow and middle coordinates; carry the fast one.
    pfim_div #(.NW(Q1W), .DW(EW), .QW(EW), .TW(ST_W + EW)) u_div_hi (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (w_lo_valid),
        .o_in_ready  (w_lo_ready),
        .i_in_num    (w_lo_quo),
        .i_in_tag    ({w_lo_tag, w_lo_rem}),
        .i_divisor   (w_dim[1]),
        .o_out_valid (w_hi_valid),
        .i_out_ready (w_hi_ready),
        .o_out_quo   (w_hi_quo),
        .o_out_rem   (w_hi_rem),
        .o_out_tag   (w_hi_tag)
    );

    assign w_crd[0] = w_hi_quo;
    assign w_crd[1] = w_hi_rem;
    assign w_crd[2] = w_hi_tag[EW-1:0];

    pfim_compose #(.EW(EW)) u_compose (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (w_cfg),
        .i_dim        (w_dim),
        .i_shape_1    (w_shape[1]),
        .i_shape_2    (w_shape[2]),
        .i_in_valid   (w_hi_valid),
        .o_in_ready   (w_hi_ready),
        .i_crd        (w_crd),
        .i_status     (t_status'(w_hi_tag[ST_W+EW-1:EW])),
        .o_out_valid  (o_out.valid),
        .i_out_ready  (o_out.ready),
        .o_out_index  (o_out.src_index),
        .o_out_status (o_out.status)
    );

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && (o_out.status != ST_OK) |-> (o_out.src_index == '0))
        else $error("error result carries a nonzero index");

    a_rst_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid)
        else $error("result valid right after reset");

endmodule

/* hw/rtl/pfim_cfg.sv */
// Configuration register file with write decode.
`timescale 1ns / 1ps

module pfim_cfg import pfim_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    pfim_cfg_if.sink i_cfg,
    output t_cfg     o_cfg
);

    t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (i_cfg.index)
                REG_BASE_SIZE_0:  r_cfg.size[0] <= i_cfg.data;
                REG_BASE_SIZE_1:  r_cfg.size[1] <= i_cfg.data;
                REG_BASE_SIZE_2:  r_cfg.size[2] <= i_cfg.data;
                REG_AXIS_PICK_0:  r_cfg.pick[0] <= i_cfg.data[PICK_W-1:0];
                REG_AXIS_PICK_1:  r_cfg.pick[1] <= i_cfg.data[PICK_W-1:0];
                REG_AXIS_PICK_2:  r_cfg.pick[2] <= i_cfg.data[PICK_W-1:0];
                REG_REVERSE_MASK: r_cfg.rev     <= i_cfg.data[REV_W-1:0];
                default: begin
                end
            endcase
        end
    end

    a_rev_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg.valid && i_cfg.ready && (i_cfg.index == REG_REVERSE_MASK)
        |=> r_cfg.rev == $past(i_cfg.data[REV_W-1:0]))
        else $error("reverse mask write not taken");

endmodule

/* hw/rtl/pfim_check.sv */
// Front stages: permutation and extent checks, element count and range test.
`timescale 1ns / 1ps

module pfim_check import pfim_pkg::*; #(
    parameter int unsigned EW = 11
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cfg             i_cfg,
    input  logic [EW-1:0]    i_dim [3],
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [IDX_W-1:0] i_in_index,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [IDX_W-1:0] o_out_index,
    output t_status          o_out_status
);

    localparam int unsigned CNTW = (IDX_W > 3 * EW) ? IDX_W : 3 * EW;
    localparam logic [3:0]  PERM_FULL = 4'b0111;

    logic [3:0]      w_seen;
    logic            w_perm_ok;
    logic            w_zero;

    logic             r_va, r_vb, r_vc;
    logic             w_rdy_a, w_rdy_b, w_rdy_c;
    logic [IDX_W-1:0] r_idx_a, r_idx_b, r_idx_c;
    logic             r_bad_a, r_bad_b;
    logic             r_zero_a, r_zero_b;
    logic [2*EW-1:0]  r_p01_a;
    logic [3*EW-1:0]  r_cnt_b;
    t_status          r_status_c;
    t_status          n_status;

    always_comb begin
        w_seen = 4'b0000;
        for (int k = 0; k < 3; k++) begin
            w_seen[i_cfg.pick[k]] = 1'b1;
        end
    end

    assign w_perm_ok = (w_seen == PERM_FULL);
    assign w_zero    = (i_dim[0] == '0) || (i_dim[1] == '0) || (i_dim[2] == '0);

    assign w_rdy_c     = !r_vc || i_out_ready;
    assign w_rdy_b     = !r_vb || w_rdy_c;
    assign w_rdy_a     = !r_va || w_rdy_b;
    assign o_in_ready  = w_rdy_a;
    assign o_out_valid = r_vc;
    assign o_out_index = r_idx_c;
    assign o_out_status = r_status_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
        end else begin
            if (w_rdy_a) r_va <= i_in_valid;
            if (w_rdy_b) r_vb <= r_va;
            if (w_rdy_c) r_vc <= r_vb;
        end
    end

    // Stage A: flags and the product of the two slower extents.
    always_ff @(posedge i_clk) begin
        if (w_rdy_a && i_in_valid) begin
            r_idx_a  <= i_in_index;
            r_bad_a  <= !w_perm_ok;
            r_zero_a <= w_zero;
            r_p01_a  <= (2 * EW)'(i_dim[0]) * (2 * EW)'(i_dim[1]);
        end
    end

    // Stage B: full element count.
    always_ff @(posedge i_clk) begin
        if (w_rdy_b && r_va) begin
            r_idx_b  <= r_idx_a;
            r_bad_b  <= r_bad_a;
            r_zero_b <= r_zero_a;
            r_cnt_b  <= (3 * EW)'(r_p01_a) * (3 * EW)'(i_dim[2]);
        end
    end

    // Stage C: first failing check wins.
    always_comb begin
        if (r_bad_b) begin
            n_status = ST_BAD_PERM;
        end else if (r_zero_b) begin
            n_status = ST_ZERO_DIM;
        end else if (CNTW'(r_idx_b) >= CNTW'(r_cnt_b)) begin
            n_status = ST_RANGE;
        end else begin
            n_status = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy_c && r_vb) begin
            r_idx_c    <= r_idx_b;
            r_status_c <= n_status;
        end
    end

endmodule

/* hw/rtl/pfim_div.sv */
// Pipelined restoring divider, one quotient bit per stage, with side tag.
`timescale 1ns / 1ps

module pfim_div #(
    parameter int unsigned NW = 30,
    parameter int unsigned DW = 11,
    parameter int unsigned QW = 22,
    parameter int unsigned TW = 2
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  logic [NW-1:0] i_in_num,
    input  logic [TW-1:0] i_in_tag,
    input  logic [DW-1:0] i_divisor,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output logic [QW-1:0] o_out_quo,
    output logic [DW-1:0] o_out_rem,
    output logic [TW-1:0] o_out_tag
);

    localparam int unsigned CW = (NW > DW + QW) ? NW : DW + QW;

    logic          r_vld [QW];
    logic [NW-1:0] r_rem [QW];
    logic [QW-1:0] r_quo [QW];
    logic [TW-1:0] r_tag [QW];
    logic          w_rdy [QW+1];

    assign w_rdy[QW]   = i_out_ready;
    assign o_in_ready  = w_rdy[0];
    assign o_out_valid = r_vld[QW-1];
    assign o_out_quo   = r_quo[QW-1];
    assign o_out_rem   = r_rem[QW-1][DW-1:0];
    assign o_out_tag   = r_tag[QW-1];

    for (genvar s = 0; s < QW; s++) begin : g_stage
        localparam int unsigned SH = QW - 1 - s;

        logic          w_vld_in;
        logic [NW-1:0] w_rem_in;
        logic [QW-1:0] w_quo_in;
        logic [TW-1:0] w_tag_in;
        logic [CW-1:0] w_trial;
        logic          w_ge;
        logic [NW-1:0] n_rem;
        logic [QW-1:0] n_quo;

        if (s == 0) begin : g_head
            assign w_vld_in = i_in_valid;
            assign w_rem_in = i_in_num;
            assign w_quo_in = '0;
            assign w_tag_in = i_in_tag;
        end else begin : g_body
            assign w_vld_in = r_vld[s-1];
            assign w_rem_in = r_rem[s-1];
            assign w_quo_in = r_quo[s-1];
            assign w_tag_in = r_tag[s-1];
        end

        // Trial subtract of the divisor aligned to this quotient bit.
        assign w_trial = CW'(i_divisor) << SH;
        assign w_ge    = CW'(w_rem_in) >= w_trial;

        always_comb begin
            n_rem = w_rem_in;
            n_quo = w_quo_in;
            if (w_ge) begin
                n_rem     = NW'(CW'(w_rem_in) - w_trial);
                n_quo[SH] = 1'b1;
            end
        end

        assign w_rdy[s] = !r_vld[s] || w_rdy[s+1];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (w_rdy[s]) begin
                r_vld[s] <= w_vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_rdy[s] && w_vld_in) begin
                r_rem[s] <= n_rem;
                r_quo[s] <= n_quo;
                r_tag[s] <= w_tag_in;
            end
        end
    end

    for (genvar s = 0; s < QW; s++) begin : g_chk
        a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            r_vld[s] && !w_rdy[s+1] |=> r_vld[s] && $stable(r_rem[s]) && $stable(r_quo[s]))
            else $error("divider stage dropped a stalled request");
    end

endmodule

/* hw/rtl/pfim_compose.sv */
// Back stages: axis reversal, reorder to base axes and row-major linearize.
`timescale 1ns / 1ps

module pfim_compose import pfim_pkg::*; #(
    parameter int unsigned EW = 11
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cfg             i_cfg,
    input  logic [EW-1:0]    i_dim [3],
    input  logic [EW-1:0]    i_shape_1,
    input  logic [EW-1:0]    i_shape_2,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [EW-1:0]    i_crd [3],
    input  t_status          i_status,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [IDX_W-1:0] o_out_index,
    output t_status          o_out_status
);

    localparam int unsigned SW = 3 * EW;

    logic            r_vd, r_ve, r_vf;
    logic            w_rdy_d, w_rdy_e, w_rdy_f;
    logic [EW-1:0]   w_flip [3];
    logic [EW-1:0]   w_base [3];
    logic [EW-1:0]   r_base_d [3];
    t_status         r_status_d, r_status_e, r_status_f;
    logic [2*EW-1:0] r_lin_e;
    logic [EW-1:0]   r_base2_e;
    logic [SW-1:0]   w_full;
    logic [IDX_W-1:0] r_index_f;

    assign w_rdy_f      = !r_vf || i_out_ready;
    assign w_rdy_e      = !r_ve || w_rdy_f;
    assign w_rdy_d      = !r_vd || w_rdy_e;
    assign o_in_ready   = w_rdy_d;
    assign o_out_valid  = r_vf;
    assign o_out_index  = r_index_f;
    assign o_out_status = r_status_f;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vd <= 1'b0;
            r_ve <= 1'b0;
            r_vf <= 1'b0;
        end else begin
            if (w_rdy_d) r_vd <= i_in_valid;
            if (w_rdy_e) r_ve <= r_vd;
            if (w_rdy_f) r_vf <= r_ve;
        end
    end

    // Mirror flipped output axes, then route each to its base axis.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (i_cfg.rev[k]) w_flip[k] = i_dim[k] - EW'(1) - i_crd[k];
            else              w_flip[k] = i_crd[k];
        end
        for (int j = 0; j < 3; j++) begin
            w_base[j] = '0;
            for (int k = 0; k < 3; k++) begin
                if (i_cfg.pick[k] == PICK_W'(j)) w_base[j] = w_flip[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy_d && i_in_valid) begin
            r_base_d   <= w_base;
            r_status_d <= i_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy_e && r_vd) begin
            r_lin_e    <= (2 * EW)'(r_base_d[0]) * (2 * EW)'(i_shape_1)
                        + (2 * EW)'(r_base_d[1]);
            r_base2_e  <= r_base_d[2];
            r_status_e <= r_status_d;
        end
    end

    assign w_full = SW'(r_lin_e) * SW'(i_shape_2) + SW'(r_base2_e);

    // Force the index to zero on any error.
    always_ff @(posedge i_clk) begin
        if (w_rdy_f && r_ve) begin
            r_index_f  <= (r_status_e == ST_OK) ? IDX_W'(w_full) : '0;
            r_status_f <= r_status_e;
        end
    end

endmodule

/* tb/sv/testbench.sv */
// Self-checking testbench for the permuted and flipped 3D index map.
`timescale 1ns / 1ps

module testbench;
    import pfim_pkg::*;

    localparam int unsigned MAX_EXTENT   = 1024;
    localparam int unsigned RANDOM_ITEMS = 1900;
    localparam int unsigned IDLE_LIMIT   = 2000;
    localparam int unsigned DRAIN_CYCLES = 60;
    localparam int unsigned MAX_REPORTS  = 10;

    // Register index past the last one; a write there must change nothing.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    typedef struct packed {
        logic [IDX_W-1:0] src_index;
        t_status          status;
    } t_map_result;

    // Receiver stall behavior, drawn anew at random whenever rx_cycle wraps.
    typedef enum logic [1:0] {
        RX_STREAM,
        RX_SPARSE,
        RX_CHOPPY,
        RX_BLOCKING
    } t_rx_mode;

    logic i_clk;
    logic i_rst_n;

    pfim_in_if  req_if ();
    pfim_out_if res_if ();
    pfim_cfg_if cfg_if ();

    permuted_flipped_3d_index_map #(
        .MAX_EXTENT(MAX_EXTENT)
    ) DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (req_if),
        .o_out  (res_if),
        .i_cfg  (cfg_if)
    );

    // Shadow of the register file, updated at each accepted write.
    t_cfg cfg_shadow;

    logic [IDX_W-1:0] pending_requests [$];
    t_map_result      expected_results [$];
    int unsigned      mismatch_count;

    // Driver state.
    logic             req_taken;
    logic             next_valid;
    logic [IDX_W-1:0] next_index;
    int unsigned      burst_left;
    int unsigned      gap_left;

    // Receiver state.
    t_rx_mode         rx_mode;
    logic             next_ready;
    logic [6:0]       rx_cycle;
    int unsigned      stall_left;

    int unsigned      idle_cycles;
    t_map_result      want;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Extent of one base axis after saturation to MAX_EXTENT.
    function automatic longint unsigned clamped_extent(input int axis);
        longint unsigned ext;
        ext = longint'(cfg_shadow.size[axis]);
        return (ext > MAX_EXTENT) ? longint'(MAX_EXTENT) : ext;
    endfunction

    function automatic longint unsigned element_count();
        return clamped_extent(0) * clamped_extent(1) * clamped_extent(2);
    endfunction

    // Map an index of the permuted, flipped view to the base array index.
    function automatic t_map_result map_to_base(input logic [IDX_W-1:0] view_idx);
        t_map_result     res;
        logic [3:0]      axes_seen;
        longint unsigned ext  [3];
        longint unsigned dim  [3];
        longint unsigned crd  [3];
        longint unsigned pos  [3];
        longint unsigned total;
        longint unsigned c;
        res.src_index = '0;
        res.status    = ST_OK;
        axes_seen     = '0;
        for (int k = 0; k < 3; k++) begin
            ext[k] = clamped_extent(k);
            axes_seen[cfg_shadow.pick[k]] = 1'b1;
        end
        // Check the permutation first, then the extents, then the index.
        if (axes_seen != 4'b0111) begin
            res.status = ST_BAD_PERM;
            return res;
        end
        for (int k = 0; k < 3; k++)
            dim[k] = ext[cfg_shadow.pick[k]];
        total = dim[0] * dim[1] * dim[2];
        if (total == 0) begin
            res.status = ST_ZERO_DIM;
            return res;
        end
        if (longint'(view_idx) >= total) begin
            res.status = ST_RANGE;
            return res;
        end
        crd[0] = longint'(view_idx) / (dim[1] * dim[2]);
        crd[1] = (longint'(view_idx) / dim[2]) % dim[1];
        crd[2] = longint'(view_idx) % dim[2];
        for (int k = 0; k < 3; k++) begin
            c = crd[k];
            if (cfg_shadow.rev[k])
                c = dim[k] - 1 - c;
            pos[cfg_shadow.pick[k]] = c;
        end
        res.src_index = IDX_W'((pos[0] * ext[1] + pos[1]) * ext[2] + pos[2]);
        return res;
    endfunction

    // Write one register; update the shadow at the accepting edge.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] reg_idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= reg_idx;
        cfg_if.data  <= value;
        do @(posedge i_clk); while (cfg_if.ready !== 1'b1);
        case (reg_idx)
            REG_BASE_SIZE_0:  cfg_shadow.size[0] = value;
            REG_BASE_SIZE_1:  cfg_shadow.size[1] = value;
            REG_BASE_SIZE_2:  cfg_shadow.size[2] = value;
            REG_AXIS_PICK_0:  cfg_shadow.pick[0] = value[PICK_W-1:0];
            REG_AXIS_PICK_1:  cfg_shadow.pick[1] = value[PICK_W-1:0];
            REG_AXIS_PICK_2:  cfg_shadow.pick[2] = value[PICK_W-1:0];
            REG_REVERSE_MASK: cfg_shadow.rev     = value[REV_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    // Write all seven registers; junk in the unused upper bits must be dropped.
    task automatic apply_config(input logic [SIZE_W-1:0] s0, s1, s2,
                                input logic [PICK_W-1:0] p0, p1, p2,
                                input logic [REV_W-1:0]  rev);
        write_reg(REG_BASE_SIZE_0, s0);
        write_reg(REG_BASE_SIZE_1, s1);
        write_reg(REG_BASE_SIZE_2, s2);
        write_reg(REG_AXIS_PICK_0, {(CFG_DATA_W-PICK_W)'($urandom), p0});
        write_reg(REG_AXIS_PICK_1, {(CFG_DATA_W-PICK_W)'($urandom), p1});
        write_reg(REG_AXIS_PICK_2, {(CFG_DATA_W-PICK_W)'($urandom), p2});
        write_reg(REG_REVERSE_MASK, {(CFG_DATA_W-REV_W)'($urandom), rev});
    endtask

    // Hold until every queued request went in and every result came back.
    // Look at the rising edge, where the driver's outputs are settled.
    task automatic settle();
        while (pending_requests.size() != 0 || req_if.valid
               || expected_results.size() != 0)
            @(posedge i_clk);
    endtask

    // Main sequence: reset, directed phases, then random phases.
    initial begin
        logic [SIZE_W-1:0] sz [3];
        logic [PICK_W-1:0] perm [3];
        logic [PICK_W-1:0] tmp;
        logic [IDX_W-1:0]  view_idx;
        longint unsigned   total;
        int unsigned       n;
        int unsigned       j;
        int unsigned       random_sent;

        cfg_shadow       = CFG_RESET;
        mismatch_count   = 0;
        random_sent      = 0;
        i_rst_n          = 1'b0;
        req_if.valid     = 1'b0;
        req_if.out_index = '0;
        res_if.ready     = 1'b0;
        cfg_if.valid     = 1'b0;
        cfg_if.index     = '0;
        cfg_if.data      = '0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset configuration: a single element, so only index 0 is in range.
        pending_requests.push_back('0);
        pending_requests.push_back(IDX_W'(1));
        pending_requests.push_back('1);
        settle();

        // Full 1024 cube, rotated axes, every axis reversed.
        apply_config(11'd1024, 11'd1024, 11'd1024, 2'd2, 2'd0, 2'd1, 3'b111);
        pending_requests.push_back('0);
        pending_requests.push_back('1);
        pending_requests.push_back(30'h2AAA_AAAA);
        pending_requests.push_back(30'h1555_5555);
        settle();

        // Oversized extent saturates; probe the last element and one past it.
        apply_config(11'd2047, 11'd3, 11'd5, 2'd1, 2'd2, 2'd0, 3'b101);
        total = element_count();
        pending_requests.push_back('0);
        pending_requests.push_back(IDX_W'(total - 1));
        pending_requests.push_back(IDX_W'(total));
        pending_requests.push_back(IDX_W'(777));
        settle();

        // Zero extent on base axis 1.
        write_reg(REG_BASE_SIZE_1, '0);
        write_reg(REG_AXIS_PICK_0, CFG_DATA_W'(0));
        write_reg(REG_AXIS_PICK_1, CFG_DATA_W'(1));
        write_reg(REG_AXIS_PICK_2, CFG_DATA_W'(2));
        write_reg(REG_REVERSE_MASK, CFG_DATA_W'(3'b010));
        pending_requests.push_back('0);
        pending_requests.push_back(IDX_W'(4));
        settle();

        // Bad permutation wins over the zero extent: a pick naming no axis...
        write_reg(REG_AXIS_PICK_0, CFG_DATA_W'(AXIS_INVALID));
        pending_requests.push_back('0);
        settle();
        // ...and a repeated axis.
        write_reg(REG_AXIS_PICK_0, CFG_DATA_W'(0));
        write_reg(REG_AXIS_PICK_1, CFG_DATA_W'(0));
        pending_requests.push_back(IDX_W'(5));
        settle();

        // Write past the last register, then a reversed valid setup.
        write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
        apply_config(11'd4, 11'd7, 11'd6, 2'd2, 2'd1, 2'd0, 3'b011);
        total = element_count();
        pending_requests.push_back(IDX_W'(3));
        pending_requests.push_back(IDX_W'(total - 1));
        settle();

        // Random phases: new configuration each time, then a batch of requests.
        while (random_sent < RANDOM_ITEMS) begin
            for (int k = 0; k < 3; k++) begin
                case ($urandom_range(0, 19))
                    0:       sz[k] = '0;
                    1, 2:    sz[k] = SIZE_W'(MAX_EXTENT);
                    3:       sz[k] = SIZE_W'($urandom_range(MAX_EXTENT + 1, 2047));
                    4, 5, 6: sz[k] = SIZE_W'($urandom_range(1, MAX_EXTENT));
                    default: sz[k] = SIZE_W'($urandom_range(1, 12));
                endcase
            end
            // Shuffle a valid permutation; now and then scramble it.
            perm[0] = 2'd0;
            perm[1] = 2'd1;
            perm[2] = 2'd2;
            j = $urandom_range(0, 2);
            tmp = perm[0]; perm[0] = perm[j]; perm[j] = tmp;
            j = $urandom_range(1, 2);
            tmp = perm[1]; perm[1] = perm[j]; perm[j] = tmp;
            if ($urandom_range(0, 7) == 0) begin
                for (int k = 0; k < 3; k++)
                    perm[k] = PICK_W'($urandom_range(0, 3));
            end
            apply_config(sz[0], sz[1], sz[2], perm[0], perm[1], perm[2],
                         REV_W'($urandom));
            if ($urandom_range(0, 5) == 0)
                write_reg(REG_UNUSED, CFG_DATA_W'($urandom));

            total = element_count();
            n = $urandom_range(40, 120);
            for (int i = 0; i < n; i++) begin
                case ($urandom_range(0, 9))
                    0: view_idx = '0;
                    1: view_idx = (total != 0) ? IDX_W'(total - 1) : '0;
                    2: view_idx = IDX_W'(total + $urandom_range(0, 3));
                    3: view_idx = IDX_W'($urandom);
                    default:
                        view_idx = (total != 0)
                                 ? IDX_W'($urandom_range(0, 32'(total - 1)))
                                 : IDX_W'($urandom);
                endcase
                pending_requests.push_back(view_idx);
            end
            random_sent += n;
            settle();
        end

        // Let the pipeline drain before the verdict.
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("[permuted_flipped_3d_index_map] OK");
        end else begin
            $display("[permuted_flipped_3d_index_map] ERROR");
        end
        $finish;
    end

    // Predict at request acceptance; configuration is stable while requests flow.
    always @(posedge i_clk) begin
        if (i_rst_n && req_if.valid && req_if.ready) begin
            expected_results.push_back(map_to_base(req_if.out_index));
            req_taken = 1'b1;
        end
    end

    // Request driver: bursts of random length separated by random gaps.
    // Hold the current request until it is taken, then advance.
    initial begin
        req_taken  = 1'b0;
        next_valid = 1'b0;
        next_index = '0;
        burst_left = 1;
        gap_left   = 0;
    end

    always @(negedge i_clk) begin
        if (req_if.valid && !req_taken) begin
            // hold: request still waiting for ready
        end else if (gap_left != 0) begin
            gap_left--;
            next_valid = 1'b0;
        end else if (pending_requests.size() != 0) begin
            next_valid = 1'b1;
            next_index = pending_requests.pop_front();
            if (burst_left <= 1) begin
                burst_left = $urandom_range(1, 40);
                // A third of the bursts run straight into the next one.
                gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            end else begin
                burst_left--;
            end
        end else begin
            next_valid = 1'b0;
        end
        req_taken = 1'b0;
        req_if.valid     <= next_valid;
        req_if.out_index <= next_index;
    end

    // Result receiver: stall pattern draws a new mode whenever rx_cycle wraps; the
    // blocking mode holds ready low long enough to back up the pipeline.
    initial begin
        rx_mode    = RX_STREAM;
        rx_cycle   = '0;
        stall_left = 0;
        next_ready = 1'b1;
    end

    always @(negedge i_clk) begin
        rx_cycle++;
        if (rx_cycle == '0)
            rx_mode = t_rx_mode'($urandom_range(0, 3));
        if (stall_left != 0) begin
            stall_left--;
            next_ready = 1'b0;
        end else begin
            case (rx_mode)
                RX_STREAM: next_ready = 1'b1;
                RX_SPARSE: next_ready = ($urandom_range(0, 3) != 0);
                RX_CHOPPY: next_ready = 1'($urandom_range(0, 1));
                RX_BLOCKING: begin
                    if ($urandom_range(0, 31) == 0) begin
                        stall_left = $urandom_range(10, 60);
                        next_ready = 1'b0;
                    end else begin
                        next_ready = 1'b1;
                    end
                end
                default: next_ready = 1'b1;
            endcase
        end
        res_if.ready <= next_ready;
    end

    // Compare each result with the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (expected_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected result: src_index %0d status %s",
                             res_if.src_index, res_if.status.name());
            end else begin
                want = expected_results.pop_front();
                if (res_if.src_index !== want.src_index
                    || res_if.status !== want.status) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("mismatch: expected %0d/%s, got %0d/%s",
                                 want.src_index, want.status.name(),
                                 res_if.src_index, res_if.status.name());
                end
            end
        end
    end

    // Watchdog: drop the run after too long without any accepted transfer.
    initial idle_cycles = 0;

    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)
            || (cfg_if.valid && cfg_if.ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("[permuted_flipped_3d_index_map] ERROR");
                $finish;
            end
        end
    end

endmodule

/* files.f */
hw/rtl/pfim_pkg.sv
hw/rtl/pfim_if.sv
hw/rtl/pfim_cfg.sv
hw/rtl/pfim_check.sv
hw/rtl/pfim_div.sv
hw/rtl/pfim_compose.sv
hw/rtl/permuted_flipped_3d_index_map.sv
tb/sv/testbench.sv
